// ===== hdl/pbb_pkg.sv =====
// Shared constants and types for the projection bounding box block.
package pbb_pkg;

  // Largest frame the column store holds.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field widths.
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int OUT_W   = 10;
  localparam int CFG_IDX_W = 2;

  // Column address and row position widths.
  localparam int COL_AW = $clog2(MAX_WIDTH);
  localparam int ROW_AW = $clog2(MAX_HEIGHT);

  // Ten times a count needs four more bits.
  localparam int TEN_W = CFG_W + 4;

  // Reset value of both size registers.
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);

  // Pixel value that is counted.
  localparam logic [PIX_W-1:0] PIX_WHITE = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_RUN,
    ST_DRAIN,
    ST_SCAN,
    ST_TAIL,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/pbb_pix_if.sv =====
// Input channel that carries one gray pixel per item.
interface pbb_pix_if
  import pbb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ===== hdl/pbb_box_if.sv =====
// Result channel that carries one bounding box per item.
interface pbb_box_if
  import pbb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] top_row;
  logic [OUT_W-1:0] bottom_row;
  logic [OUT_W-1:0] left_col;
  logic [OUT_W-1:0] right_col;

  modport source (output valid, output top_row, output bottom_row, output left_col,
                  output right_col, input ready);
  modport sink (input valid, input top_row, input bottom_row, input left_col,
                input right_col, output ready);
endinterface

// ===== hdl/projection_bounding_box.sv =====
// Top level: row and column projection counts and bounding box of white pixels.
// Throughput: one pixel item per cycle within a frame; the input then stalls while
// the column store is scanned, one column a cycle, and until the box item is emitted.
// The box item is registered in the emit state, which follows the drain, scan and tail states.
// Reset: synchronous, active low; clears all counters and loads 1024 into both sizes.
// The column store needs no clearing pass: the first row of each frame overwrites it.
module projection_bounding_box
  import pbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  pbb_pix_if.sink              in_ch,
  pbb_box_if.source            out_ch
);

  // Register value to effective size: zero becomes one, large values saturate.
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int maxv);
    logic [CFG_W-1:0] res;
    begin
      if (v == '0) begin
        res = CFG_W'(1);
      end else if (int'(v) > maxv) begin
        res = CFG_W'(maxv);
      end else begin
        res = v;
      end
      return res;
    end
  endfunction

  // Ten times a count, as shifts and an add.
  function automatic logic [TEN_W-1:0] times_ten(input logic [CFG_W-1:0] v);
    logic [TEN_W-1:0] ext;
    begin
      ext = TEN_W'(v);
      return (ext << 3) + (ext << 1);
    end
  endfunction

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  w_r, h_r;
  logic [CFG_W-1:0]  row_cnt_r;
  logic [COL_AW-1:0] col_pos_r;
  logic [ROW_AW-1:0] row_pos_r;
  logic              top_seen_r;
  logic [ROW_AW-1:0] top_found_r, bottom_found_r;
  logic              left_seen_r;
  logic [COL_AW-1:0] left_r, right_r;

  // Column store and its read-modify-write pipeline.
  logic [CFG_W-1:0]  col_mem [MAX_WIDTH];
  logic [CFG_W-1:0]  mem_rd_r;
  logic              p1_valid_r;
  logic [COL_AW-1:0] p1_col_r;
  logic              p1_white_r;
  logic              p1_fresh_r;
  logic              fwd_hit_r;
  logic [CFG_W-1:0]  fwd_data_r;
  logic [CFG_W-1:0]  base_cnt;
  logic [CFG_W-1:0]  wr_data;

  // Column scan.
  logic [COL_AW-1:0] scan_addr_r;
  logic              s1_valid_r;
  logic [COL_AW-1:0] s1_col_r;
  logic              col_hit;

  // Output register.
  logic              out_valid_r;
  logic [OUT_W-1:0]  top_row_r, bottom_row_r, left_col_r, right_col_r;

  // Sequencer outputs.
  logic              in_ready;
  logic              rd_en;
  logic [COL_AW-1:0] rd_addr;
  logic              scan_step;
  logic              emit;

  logic              pix_acc;
  logic              is_white;
  logic              row_end;
  logic              frame_end;
  logic [CFG_W-1:0]  row_cnt_inc;
  logic              row_hit;
  logic              scan_last;
  logic              cfg_hit;

  assign pix_acc     = in_ch.valid && in_ready;
  assign is_white    = (in_ch.pixel == PIX_WHITE);
  assign row_end     = (col_pos_r == COL_AW'(w_r - CFG_W'(1)));
  assign frame_end   = row_end && (row_pos_r == ROW_AW'(h_r - CFG_W'(1)));
  assign row_cnt_inc = row_cnt_r + CFG_W'(is_white);
  assign row_hit     = times_ten(row_cnt_inc) > TEN_W'(w_r);
  assign scan_last   = (scan_addr_r == COL_AW'(w_r - CFG_W'(1)));
  assign cfg_hit     = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                                  (cfg_index == REG_FRAME_HEIGHT));

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and controls.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = col_pos_r;
    scan_step = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_ready = 1'b1;
        rd_en    = in_ch.valid;
        if (pix_acc && frame_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        rd_en     = 1'b1;
        rd_addr   = scan_addr_r;
        scan_step = 1'b1;
        if (scan_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit      = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  // Frame size registers hold the effective size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= eff_size(SIZE_RESET, MAX_WIDTH);
      h_r <= eff_size(SIZE_RESET, MAX_HEIGHT);
    end else if (cfg_we && (cfg_index == REG_FRAME_WIDTH)) begin
      w_r <= eff_size(cfg_data, MAX_WIDTH);
    end else if (cfg_we && (cfg_index == REG_FRAME_HEIGHT)) begin
      h_r <= eff_size(cfg_data, MAX_HEIGHT);
    end
  end

  // Raster position and the row test, done as each pixel is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      row_cnt_r      <= '0;
      col_pos_r      <= '0;
      row_pos_r      <= '0;
      top_seen_r     <= 1'b0;
      top_found_r    <= '0;
      bottom_found_r <= '0;
    end else if (emit) begin
      top_seen_r     <= 1'b0;
      top_found_r    <= '0;
      bottom_found_r <= '0;
    end else if (pix_acc) begin
      if (row_end) begin
        row_cnt_r <= '0;
        col_pos_r <= '0;
        row_pos_r <= frame_end ? '0 : row_pos_r + ROW_AW'(1);
        if (row_hit) begin
          if (!top_seen_r) begin
            top_seen_r  <= 1'b1;
            top_found_r <= row_pos_r;
          end
          bottom_found_r <= row_pos_r;
        end
      end else begin
        row_cnt_r <= row_cnt_inc;
        col_pos_r <= col_pos_r + COL_AW'(1);
      end
    end
  end

  // Stage after the read: the first row starts every column from zero.
  assign base_cnt = p1_fresh_r ? '0 : (fwd_hit_r ? fwd_data_r : mem_rd_r);
  assign wr_data  = base_cnt + CFG_W'(p1_white_r);

  // Pipeline control of the read-modify-write path and the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      fwd_hit_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      scan_addr_r <= '0;
    end else begin
      p1_valid_r <= pix_acc;
      fwd_hit_r  <= p1_valid_r && rd_en && (rd_addr == p1_col_r);
      s1_valid_r <= scan_step;
      if (scan_step) begin
        scan_addr_r <= scan_last ? '0 : scan_addr_r + COL_AW'(1);
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    p1_col_r   <= col_pos_r;
    p1_white_r <= is_white;
    p1_fresh_r <= (row_pos_r == '0);
    fwd_data_r <= wr_data;
    s1_col_r   <= scan_addr_r;
  end

  // Column store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (p1_valid_r) begin
      col_mem[p1_col_r] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_r <= col_mem[rd_addr];
    end
  end

  // Column test on scanned counts.
  assign col_hit = s1_valid_r && (times_ten(mem_rd_r) > TEN_W'(h_r));

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit || emit) begin
      left_seen_r <= 1'b0;
      left_r      <= '0;
      right_r     <= '0;
    end else if (col_hit) begin
      if (!left_seen_r) begin
        left_seen_r <= 1'b1;
        left_r      <= s1_col_r;
      end
      right_r <= s1_col_r;
    end
  end

  // Output register, loaded once per frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      top_row_r    <= OUT_W'(top_found_r);
      bottom_row_r <= OUT_W'(bottom_found_r);
      left_col_r   <= OUT_W'(left_r);
      right_col_r  <= OUT_W'(right_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.top_row    = top_row_r;
  assign out_ch.bottom_row = bottom_row_r;
  assign out_ch.left_col   = left_col_r;
  assign out_ch.right_col  = right_col_r;

endmodule

// ===== hdl/pbb_checker.sv =====
// Port-level checks of the projection bounding box block, bound to the top level.
module pbb_port_checks
  import pbb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] top_row,
  input logic [OUT_W-1:0] bottom_row,
  input logic [OUT_W-1:0] left_col,
  input logic [OUT_W-1:0] right_col
);

  // A waiting result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A waiting result item keeps its box.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(top_row) && $stable(bottom_row) &&
                                $stable(left_col) && $stable(right_col))
    else $error("result item changed while stalled");

  // The first qualifying line never lies after the last one.
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (top_row <= bottom_row) && (left_col <= right_col))
    else $error("bounding box edges out of order");

  // A new result follows the column scan, when input is held off.
  a_emit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result item raised while pixels were being taken");

endmodule

bind projection_bounding_box pbb_port_checks u_pbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .top_row    (out_ch.top_row),
  .bottom_row (out_ch.bottom_row),
  .left_col   (out_ch.left_col),
  .right_col  (out_ch.right_col)
);
